// ----- design/single_line_write_back_cache_assert.svh -----
// ----------------------------------------------------------------------------
// single_line_write_back_cache assertion macros
// concurrent property checks, empty bodies in synthesis
// ----------------------------------------------------------------------------
`ifndef SINGLE_LINE_WRITE_BACK_CACHE_ASSERT_SVH
`define SINGLE_LINE_WRITE_BACK_CACHE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SLWBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slwbc assertion failed");

// next-cycle implication
`define SLWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slwbc assertion failed");

`else

`define SLWBC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/slwbc_pkg.sv -----
// ----------------------------------------------------------------------------
// slwbc_pkg
// shared types and constants of the single-line write-back cache
// ----------------------------------------------------------------------------
package slwbc_pkg;

    localparam int LINE_BYTES_DEF = 8;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_FILL  = 2'd2,
        OP_GRANT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_DONE      = 3'd0,
        KIND_FETCH     = 3'd1,
        KIND_FLUSH_REQ = 3'd2,
        KIND_MEM_WRITE = 3'd3,
        KIND_FWD_READ  = 3'd4,
        KIND_FWD_WRITE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_CTRL_ADDR  = 2'd1,
        CFG_FLUSH_WAIT = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        BS_IDLE  = 1'b0,
        BS_FLUSH = 1'b1
    } t_back_state;

    typedef struct packed {
        logic        enable;
        logic [15:0] control_address;
        logic [15:0] flush_wait;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [15:0] address;
        logic [7:0]  store_data;
        logic [7:0]  access_count;
        logic [63:0] fill_line;
        logic [7:0]  fill_byte;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  read_data;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [7:0]  mem_count;
        logic [15:0] wait_time;
        logic        last;
    } t_result;

endpackage

// ----- design/slwbc_front.sv -----
// ----------------------------------------------------------------------------
// slwbc_front
// accepts input beats, masks the address, splits it into line tag and
// byte offset, flags the control address and hands items to the queue
// ----------------------------------------------------------------------------
module slwbc_front #(
    parameter int  LINE_BYTES = slwbc_pkg::LINE_BYTES_DEF,
    parameter int  ADDR_BITS  = slwbc_pkg::ADDR_BITS_DEF,
    localparam int AW         = (ADDR_BITS < 16) ? ADDR_BITS : 16,
    localparam int TAG_W      = $clog2(((1 << AW) - 1) / LINE_BYTES + 1),
    localparam int OFF_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [15:0]                      i_ctrl_addr,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [slwbc_pkg::IN_DATA_W-1:0]  i_data,
    input  logic [1:0]                       i_user,
    output logic                             o_valid,
    input  logic                             i_ready,
    output slwbc_pkg::t_item                 o_item,
    output logic [TAG_W-1:0]                 o_tag,
    output logic [OFF_W-1:0]                 o_off,
    output logic                             o_ctrl
);

    localparam int SHIFT    = AW + 3;
    localparam int RECIP    = ((1 << SHIFT) + LINE_BYTES - 1) / LINE_BYTES;
    localparam int RECIP_W  = SHIFT + 1;
    localparam int PROD_W   = AW + RECIP_W;
    localparam int ADDR_MSK = (1 << AW) - 1;

    logic                 r_valid;
    slwbc_pkg::t_item     r_item;
    logic [TAG_W-1:0]     r_tag;
    logic                 r_ctrl;

    logic                 accept;
    logic [15:0]          addr_m;
    logic [PROD_W-1:0]    prod;
    logic [AW-1:0]        base;
    logic [AW-1:0]        rem;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign addr_m = i_data[15:0] & 16'(ADDR_MSK);
    // division by the line size as multiply by reciprocal
    assign prod   = PROD_W'(addr_m[AW-1:0]) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op           <= slwbc_pkg::t_op'(i_user);
            r_item.address      <= addr_m;
            r_item.store_data   <= i_data[23:16];
            r_item.access_count <= i_data[31:24];
            r_item.fill_line    <= i_data[95:32];
            r_item.fill_byte    <= i_data[103:96];
            r_tag               <= prod[SHIFT +: TAG_W];
            r_ctrl              <= (addr_m == i_ctrl_addr);
        end
    end

    assign base = AW'(AW'(r_tag) * AW'(LINE_BYTES));
    assign rem  = r_item.address[AW-1:0] - base;

    assign o_valid = r_valid;
    assign o_item  = r_item;
    assign o_tag   = r_tag;
    assign o_off   = rem[OFF_W-1:0];
    assign o_ctrl  = r_ctrl;

endmodule

// ----- design/slwbc_fifo.sv -----
// ----------------------------------------------------------------------------
// slwbc_fifo
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module slwbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = slwbc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic push;
    logic pop;

    assign o_in_ready  = (r_count != CNT_W'(DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_in_data;
        end
    end

endmodule

// ----- design/slwbc_back.sv -----
// ----------------------------------------------------------------------------
// slwbc_back
// holds the cache line and carries out queued items; a flush grant walks
// the line one byte a cycle unless the output stalls; emits written bytes
// ----------------------------------------------------------------------------
module slwbc_back #(
    parameter int  LINE_BYTES = slwbc_pkg::LINE_BYTES_DEF,
    parameter int  ADDR_BITS  = slwbc_pkg::ADDR_BITS_DEF,
    localparam int AW         = (ADDR_BITS < 16) ? ADDR_BITS : 16,
    localparam int TAG_W      = $clog2(((1 << AW) - 1) / LINE_BYTES + 1),
    localparam int OFF_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  slwbc_pkg::t_cfg       i_cfg,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  slwbc_pkg::t_item      i_item,
    input  logic [TAG_W-1:0]      i_tag,
    input  logic [OFF_W-1:0]      i_off,
    input  logic                  i_ctrl,
    output logic                  o_valid,
    input  logic                  i_ready,
    output slwbc_pkg::t_result    o_res
);

    localparam int IDX_W = $clog2(LINE_BYTES + 1);

    slwbc_pkg::t_back_state r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_out_valid, n_out_valid;
    slwbc_pkg::t_result     r_out, n_out;
    logic [TAG_W-1:0]       r_tag, n_tag;
    logic [7:0]             r_bytes [LINE_BYTES];
    logic [7:0]             n_bytes [LINE_BYTES];
    logic [LINE_BYTES-1:0]  r_dirty, n_dirty;
    logic                   r_line_valid, n_line_valid;
    logic                   r_any, n_any;
    logic                   r_saf, n_saf;
    logic [TAG_W-1:0]       r_ptag, n_ptag;
    logic [OFF_W-1:0]       r_poff, n_poff;
    logic [7:0]             r_pbyte, n_pbyte;

    logic                   out_free;
    logic [OFF_W-1:0]       cur;
    logic [16:0]            fetch_base;
    logic [16:0]            wr_addr;
    logic [7:0]             fill_b [LINE_BYTES];
    slwbc_pkg::t_result     res;
    logic                   emit;

    assign out_free   = !r_out_valid || i_ready;
    assign cur        = r_idx[OFF_W-1:0];
    assign fetch_base = 17'(i_tag) * 17'(LINE_BYTES);
    assign wr_addr    = 17'(r_tag) * 17'(LINE_BYTES) + 17'(r_idx);

    always_comb begin
        for (int i = 0; i < LINE_BYTES; i++) begin
            fill_b[i] = i_item.fill_line[8*i +: 8];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slwbc_pkg::BS_IDLE: begin
                if (i_q_valid && i_item.op == slwbc_pkg::OP_GRANT) begin
                    n_state = slwbc_pkg::BS_FLUSH;
                end
            end
            slwbc_pkg::BS_FLUSH: begin
                if (out_free && r_idx == IDX_W'(LINE_BYTES)) begin
                    n_state = slwbc_pkg::BS_IDLE;
                end
            end
            default: n_state = slwbc_pkg::BS_IDLE;
        endcase
    end

    // outputs and line updates
    always_comb begin
        n_idx        = r_idx;
        n_tag        = r_tag;
        n_bytes      = r_bytes;
        n_dirty      = r_dirty;
        n_line_valid = r_line_valid;
        n_any        = r_any;
        n_saf        = r_saf;
        n_ptag       = r_ptag;
        n_poff       = r_poff;
        n_pbyte      = r_pbyte;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        o_q_pop      = 1'b0;
        emit         = 1'b0;
        res          = '0;

        case (r_state)
            slwbc_pkg::BS_IDLE: begin
                n_idx = '0;
                if (i_q_valid && out_free && i_item.op != slwbc_pkg::OP_GRANT) begin
                    o_q_pop  = 1'b1;
                    emit     = 1'b1;
                    res.last = 1'b1;
                    case (i_item.op)
                        slwbc_pkg::OP_LOAD: begin
                            n_ptag = i_tag;
                            n_poff = i_off;
                            if (!i_cfg.enable) begin
                                res.kind        = slwbc_pkg::KIND_FWD_READ;
                                res.mem_address = i_item.address;
                                res.mem_count   = i_item.access_count;
                            end else if (i_ctrl) begin
                                n_line_valid = 1'b0;
                                n_any        = 1'b0;
                                n_dirty      = '0;
                                res.kind     = slwbc_pkg::KIND_DONE;
                            end else if (i_tag == r_tag && r_line_valid) begin
                                res.kind      = slwbc_pkg::KIND_DONE;
                                res.read_data = r_bytes[i_off];
                            end else begin
                                n_tag           = i_tag;
                                res.kind        = slwbc_pkg::KIND_FETCH;
                                res.mem_address = fetch_base[15:0];
                                res.mem_count   = 8'(LINE_BYTES);
                            end
                        end
                        slwbc_pkg::OP_STORE: begin
                            n_ptag  = i_tag;
                            n_poff  = i_off;
                            n_pbyte = i_item.store_data;
                            if (!i_cfg.enable) begin
                                res.kind        = slwbc_pkg::KIND_FWD_WRITE;
                                res.mem_address = i_item.address;
                                res.mem_data    = i_item.store_data;
                                res.mem_count   = i_item.access_count;
                            end else if (i_ctrl) begin
                                res.kind      = slwbc_pkg::KIND_FLUSH_REQ;
                                res.wait_time = i_cfg.flush_wait;
                            end else if (i_tag == r_tag || !r_any) begin
                                // tag change drops the old line first
                                if (i_tag != r_tag) begin
                                    n_line_valid = 1'b0;
                                    n_dirty      = '0;
                                end
                                n_tag          = i_tag;
                                n_bytes[i_off] = i_item.store_data;
                                n_dirty[i_off] = 1'b1;
                                n_any          = 1'b1;
                                res.kind       = slwbc_pkg::KIND_DONE;
                            end else begin
                                n_saf         = 1'b1;
                                res.kind      = slwbc_pkg::KIND_FLUSH_REQ;
                                res.wait_time = i_cfg.flush_wait;
                            end
                        end
                        slwbc_pkg::OP_FILL: begin
                            res.kind = slwbc_pkg::KIND_DONE;
                            if (i_cfg.enable) begin
                                n_line_valid  = 1'b1;
                                n_bytes       = fill_b;
                                n_dirty       = '0;
                                res.read_data = fill_b[r_poff];
                            end else begin
                                res.read_data = i_item.fill_byte;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            slwbc_pkg::BS_FLUSH: begin
                if (out_free) begin
                    if (r_idx != IDX_W'(LINE_BYTES)) begin
                        n_idx = r_idx + IDX_W'(1);
                        if (r_dirty[cur]) begin
                            emit            = 1'b1;
                            n_dirty[cur]    = 1'b0;
                            res.kind        = slwbc_pkg::KIND_MEM_WRITE;
                            res.mem_address = wr_addr[15:0];
                            res.mem_data    = r_bytes[cur];
                        end
                    end else begin
                        o_q_pop  = 1'b1;
                        emit     = 1'b1;
                        res.kind = slwbc_pkg::KIND_DONE;
                        res.last = 1'b1;
                        n_any    = 1'b0;
                        // pending store lands in a fresh line
                        if (r_saf) begin
                            n_saf           = 1'b0;
                            n_line_valid    = 1'b0;
                            n_dirty         = '0;
                            n_dirty[r_poff] = 1'b1;
                            n_tag           = r_ptag;
                            n_bytes[r_poff] = r_pbyte;
                            n_any           = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slwbc_pkg::BS_IDLE;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_tag        <= '0;
            r_dirty      <= '0;
            r_line_valid <= 1'b0;
            r_any        <= 1'b0;
            r_saf        <= 1'b0;
            r_ptag       <= '0;
            r_poff       <= '0;
            r_pbyte      <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
            r_tag        <= n_tag;
            r_dirty      <= n_dirty;
            r_line_valid <= n_line_valid;
            r_any        <= n_any;
            r_saf        <= n_saf;
            r_ptag       <= n_ptag;
            r_poff       <= n_poff;
            r_pbyte      <= n_pbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_bytes <= n_bytes;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ----- design/single_line_write_back_cache.sv -----
// ----------------------------------------------------------------------------
// single_line_write_back_cache
// one-line write-back byte cache between a cpu and memory
// ----------------------------------------------------------------------------
//  channel   direction  beat content
//  s_axis    in         tuser opcode, tdata address/store/count/line/byte
//  m_axis    out        tuser kind, tdata memory request or cpu answer, tlast
//  cfg       in         register index and write data
//
//  load, store and fill: one result, via front, queue and result registers;
//  one item a cycle while no result stalls and no flush grant runs
//  flush grant: the back walks the line byte by byte, then emits a done beat
//  reset: synchronous, no clearing pass, the block is ready at once
//  a stalled result holds the back; the two-entry queue keeps input open
// ----------------------------------------------------------------------------
`include "single_line_write_back_cache_assert.svh"

module single_line_write_back_cache #(
    parameter int LINE_BYTES = slwbc_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS  = slwbc_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // address, store_data, access_count, fill_line, fill_byte
    input  logic [slwbc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // opcode
    input  logic [1:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // read_data, mem_address, mem_data, mem_count, wait_time
    output logic [slwbc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // kind
    output logic [2:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [slwbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slwbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW     = (ADDR_BITS < 16) ? ADDR_BITS : 16;
    localparam int TAG_W  = $clog2(((1 << AW) - 1) / LINE_BYTES + 1);
    localparam int OFF_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int ITEM_W = $bits(slwbc_pkg::t_item);
    localparam int QW     = ITEM_W + TAG_W + OFF_W + 1;

    slwbc_pkg::t_cfg    r_cfg;

    logic               f_valid;
    logic               f_ready;
    slwbc_pkg::t_item   f_item;
    logic [TAG_W-1:0]   f_tag;
    logic [OFF_W-1:0]   f_off;
    logic               f_ctrl;

    logic [QW-1:0]      q_in;
    logic [QW-1:0]      q_out;
    logic               q_valid;
    logic               q_pop;

    slwbc_pkg::t_result b_res;
    logic               b_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= 1'b0;
            r_cfg.control_address <= 16'h00ff;
            r_cfg.flush_wait      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slwbc_pkg::CFG_ENABLE:     r_cfg.enable          <= i_cfg_data[0];
                slwbc_pkg::CFG_CTRL_ADDR:  r_cfg.control_address <= i_cfg_data;
                slwbc_pkg::CFG_FLUSH_WAIT: r_cfg.flush_wait      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    slwbc_front #(
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl_addr (r_cfg.control_address),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_user      (i_s_axis_tuser),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_item      (f_item),
        .o_tag       (f_tag),
        .o_off       (f_off),
        .o_ctrl      (f_ctrl)
    );

    assign q_in = {f_ctrl, f_off, f_tag, f_item};

    slwbc_fifo #(
        .WIDTH (QW),
        .DEPTH (slwbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (f_valid),
        .o_in_ready  (f_ready),
        .i_in_data   (q_in),
        .o_out_valid (q_valid),
        .i_out_ready (q_pop),
        .o_out_data  (q_out)
    );

    slwbc_back #(
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_item    (slwbc_pkg::t_item'(q_out[ITEM_W-1:0])),
        .i_tag     (q_out[ITEM_W +: TAG_W]),
        .i_off     (q_out[ITEM_W + TAG_W +: OFF_W]),
        .i_ctrl    (q_out[QW-1]),
        .o_valid   (b_valid),
        .i_ready   (i_m_axis_tready),
        .o_res     (b_res)
    );

    assign o_m_axis_tvalid = b_valid;
    assign o_m_axis_tuser  = b_res.kind;
    assign o_m_axis_tlast  = b_res.last;
    assign o_m_axis_tdata  = {b_res.wait_time, b_res.mem_count, b_res.mem_data,
                              b_res.mem_address, b_res.read_data};

    // only a memory write beat is followed by more beats of the same item
    `SLWBC_ASSERT_IMPL(a_last_kind, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tlast == (o_m_axis_tuser != slwbc_pkg::KIND_MEM_WRITE))
    // cpu data only on a done beat
    `SLWBC_ASSERT_IMPL(a_read_data_done, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != slwbc_pkg::KIND_DONE), o_m_axis_tdata[7:0] == 8'd0)
    // wait time only on a flush request
    `SLWBC_ASSERT_IMPL(a_wait_flush, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != slwbc_pkg::KIND_FLUSH_REQ), o_m_axis_tdata[55:40] == 16'd0)

endmodule
